// ===== rtl/rgb2hsv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2hsv_pkg: shared types and constants
// Channel widths, divider geometry and the beat that moves along the cell chain.
// ----------------------------------------------------------------------------
package rgb2hsv_pkg;

  localparam int unsigned ChanW   = 8;
  localparam int unsigned HueW    = 13;
  // quotient bits per division, one cell per bit
  localparam int unsigned QuotW   = 10;
  // widest numerator: 960 * 255
  localparam int unsigned NumW    = 18;
  localparam int unsigned HueSext = 1920;
  localparam int unsigned HueFull = 5760;

  typedef enum logic [1:0] {
    SEXT_RED   = 2'd0,
    SEXT_GREEN = 2'd1,
    SEXT_BLUE  = 2'd2
  } sext_e;

  typedef struct packed {
    logic [NumW-1:0]  hue_rem;
    logic [QuotW-1:0] hue_quot;
    logic [ChanW-1:0] hue_div;
    logic [NumW-1:0]  sat_rem;
    logic [QuotW-1:0] sat_quot;
    logic [ChanW-1:0] sat_div;
    logic             neg;
    sext_e            sext;
    logic             defined;
    logic [ChanW-1:0] value;
  } beat_t;

endpackage

// ===== rtl/rgb2hsv_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2hsv_front: pixel front end
// Finds max, min and sextant, forms both division numerators.
// ----------------------------------------------------------------------------
module rgb2hsv_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic [rgb2hsv_pkg::ChanW-1:0] red_i,
  input  logic [rgb2hsv_pkg::ChanW-1:0] green_i,
  input  logic [rgb2hsv_pkg::ChanW-1:0] blue_i,
  output logic                        valid_o,
  output rgb2hsv_pkg::beat_t          beat_o
);
  import rgb2hsv_pkg::*;

  logic [ChanW-1:0] max_c, min_c, diff_c, mag_c;
  logic [ChanW:0]   num_c;
  sext_e            sext_c;
  beat_t            beat_d, beat_q;
  logic             valid_q;

  always_comb begin
    max_c = (red_i > green_i) ? red_i : green_i;
    max_c = (max_c > blue_i) ? max_c : blue_i;
    min_c = (red_i < green_i) ? red_i : green_i;
    min_c = (min_c < blue_i) ? min_c : blue_i;
    diff_c = max_c - min_c;

    // first channel equal to the max picks the sextant
    if (red_i >= max_c) begin
      sext_c = SEXT_RED;
      num_c  = {1'b0, green_i} - {1'b0, blue_i};
    end else if (green_i >= max_c) begin
      sext_c = SEXT_GREEN;
      num_c  = {1'b0, blue_i} - {1'b0, red_i};
    end else begin
      sext_c = SEXT_BLUE;
      num_c  = {1'b0, red_i} - {1'b0, green_i};
    end
    mag_c = num_c[ChanW] ? ChanW'(-num_c) : num_c[ChanW-1:0];

    beat_d          = '0;
    // 960 = 1024 - 64, 255 = 256 - 1
    beat_d.hue_rem  = {mag_c, 10'b0} - NumW'({mag_c, 6'b0});
    beat_d.hue_div  = diff_c;
    beat_d.sat_rem  = NumW'({diff_c, 8'b0}) - NumW'(diff_c);
    beat_d.sat_div  = max_c;
    beat_d.neg      = num_c[ChanW];
    beat_d.sext     = sext_c;
    beat_d.defined  = (diff_c != '0);
    beat_d.value    = max_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== rtl/rgb2hsv_div_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2hsv_div_cell: one divider cell
// Resolves quotient bit Bit of both the hue and the saturation division.
// ----------------------------------------------------------------------------
module rgb2hsv_div_cell #(
  parameter int unsigned Bit = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               valid_i,
  input  rgb2hsv_pkg::beat_t beat_i,
  output logic               valid_o,
  output rgb2hsv_pkg::beat_t beat_o
);
  import rgb2hsv_pkg::*;

  logic [NumW-1:0] hue_sh, sat_sh;
  beat_t           beat_d, beat_q;
  logic            valid_q;

  always_comb begin
    hue_sh = NumW'(beat_i.hue_div) << Bit;
    sat_sh = NumW'(beat_i.sat_div) << Bit;
    beat_d = beat_i;
    if (beat_i.hue_rem >= hue_sh) begin
      beat_d.hue_rem       = beat_i.hue_rem - hue_sh;
      beat_d.hue_quot[Bit] = 1'b1;
    end
    if (beat_i.sat_rem >= sat_sh) begin
      beat_d.sat_rem       = beat_i.sat_rem - sat_sh;
      beat_d.sat_quot[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    beat_q <= beat_d;
  end

  assign valid_o = valid_q;
  assign beat_o  = beat_q;

endmodule

// ===== rtl/rgb2hsv_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb2hsv_back: result assembly
// Applies floor rounding, sextant offset and wrap, masks undefined hue.
// ----------------------------------------------------------------------------
module rgb2hsv_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  rgb2hsv_pkg::beat_t            beat_i,
  output logic                          done_o,
  output logic [rgb2hsv_pkg::HueW-1:0]  hue_o,
  output logic                          hue_defined_o,
  output logic [rgb2hsv_pkg::ChanW-1:0] sat_o,
  output logic [rgb2hsv_pkg::ChanW-1:0] value_o
);
  import rgb2hsv_pkg::*;

  logic [HueW-1:0]  base_c;
  logic [QuotW:0]   mag_c;
  logic [HueW:0]    sum_c, hue_c;
  logic             done_q, def_q;
  logic [HueW-1:0]  hue_q;
  logic [ChanW-1:0] sat_q, value_q;

  always_comb begin
    case (beat_i.sext)
      SEXT_RED:   base_c = '0;
      SEXT_GREEN: base_c = HueW'(HueSext);
      SEXT_BLUE:  base_c = HueW'(2 * HueSext);
      default:    base_c = '0;
    endcase
    // negative quotient floors away from zero
    mag_c = {1'b0, beat_i.hue_quot}
          + (QuotW+1)'(beat_i.neg && (beat_i.hue_rem != '0));
    sum_c = beat_i.neg ? {1'b0, base_c} - (HueW+1)'(mag_c)
                       : {1'b0, base_c} + (HueW+1)'(mag_c);
    hue_c = sum_c[HueW] ? sum_c + (HueW+1)'(HueFull) : sum_c;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    def_q   <= beat_i.defined;
    hue_q   <= beat_i.defined ? hue_c[HueW-1:0] : '0;
    sat_q   <= beat_i.defined ? beat_i.sat_quot[ChanW-1:0] : '0;
    value_q <= beat_i.value;
  end

  assign done_o        = done_q;
  assign hue_o         = hue_q;
  assign hue_defined_o = def_q;
  assign sat_o         = sat_q;
  assign value_o       = value_q;

endmodule

// ===== rtl/rgb_to_hsv_pixel.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_to_hsv_pixel: rgb to hsv pixel converter
// Pipelined conversion of 8-bit rgb pixels to hue, saturation and value.
// ----------------------------------------------------------------------------
// Takes one pixel every clock: busy_o stays low, so a beat is taken whenever
// start_i is high. Each result appears on the output ports for one cycle with
// done_o high, after its pixel has passed through one front stage, a chain
// of ten divider cells (one per quotient bit of the hue and saturation
// divisions) and one output stage. Results leave in input order and cannot
// be held off. Hue is in sixteenths of a degree (0..5759); for black or grey
// pixels hue_defined_o is low and hue and saturation read 0.
module rgb_to_hsv_pixel (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  output logic                          busy_o,
  input  logic [rgb2hsv_pkg::ChanW-1:0] red_in_i,
  input  logic [rgb2hsv_pkg::ChanW-1:0] green_in_i,
  input  logic [rgb2hsv_pkg::ChanW-1:0] blue_in_i,
  output logic                          done_o,
  output logic [rgb2hsv_pkg::HueW-1:0]  hue_out_o,
  output logic                          hue_defined_o,
  output logic [rgb2hsv_pkg::ChanW-1:0] saturation_out_o,
  output logic [rgb2hsv_pkg::ChanW-1:0] value_out_o
);
  import rgb2hsv_pkg::*;

  localparam int unsigned Latency = QuotW + 2;

  logic  valid_chain [QuotW+1];
  beat_t beat_chain  [QuotW+1];

  assign busy_o = 1'b0;

  rgb2hsv_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start_i),
    .red_i   (red_in_i),
    .green_i (green_in_i),
    .blue_i  (blue_in_i),
    .valid_o (valid_chain[0]),
    .beat_o  (beat_chain[0])
  );

  // msb quotient bit first
  for (genvar i = 0; i < QuotW; i++) begin : g_cell
    rgb2hsv_div_cell #(
      .Bit(QuotW - 1 - i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (valid_chain[i]),
      .beat_i  (beat_chain[i]),
      .valid_o (valid_chain[i+1]),
      .beat_o  (beat_chain[i+1])
    );
  end

  rgb2hsv_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .valid_i       (valid_chain[QuotW]),
    .beat_i        (beat_chain[QuotW]),
    .done_o        (done_o),
    .hue_o         (hue_out_o),
    .hue_defined_o (hue_defined_o),
    .sat_o         (saturation_out_o),
    .value_o       (value_out_o)
  );

`ifndef SYNTH
  a_done_follows_start : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i, Latency))
    else $error("result beat without a matching input beat");

  a_hue_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (hue_out_o < HueW'(HueFull)))
    else $error("hue out of range");

  a_undefined_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !hue_defined_o) |-> (hue_out_o == '0 && saturation_out_o == '0))
    else $error("undefined hue with non-zero hue or saturation");

  a_black_undefined : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && value_out_o == '0) |-> !hue_defined_o)
    else $error("black pixel with defined hue");
`endif

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: rgb to hsv pixel converter testbench
// Sends directed corner pixels and then random pixels with bursty starts. A
// local model predicts hue, saturation and value for each taken pixel, and
// every done beat is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
  import rgb2hsv_pkg::*;

  localparam int SextantStep = 960;
  localparam int ResultLatency = 12;

  typedef struct packed {
    logic [HueW-1:0]  hue;
    logic             defined;
    logic [ChanW-1:0] sat;
    logic [ChanW-1:0] val;
  } hsv_t;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             start_i = 1'b0;
  logic             busy_o;
  logic [ChanW-1:0] red_in_i = '0;
  logic [ChanW-1:0] green_in_i = '0;
  logic [ChanW-1:0] blue_in_i = '0;
  logic             done_o;
  logic [HueW-1:0]  hue_out_o;
  logic             hue_defined_o;
  logic [ChanW-1:0] saturation_out_o;
  logic [ChanW-1:0] value_out_o;

  hsv_t pending_hsv[$];
  int   mismatches = 0;
  int   burst_left = 0;
  bit   no_gaps = 1'b0;

  rgb_to_hsv_pixel dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (start_i),
    .busy_o          (busy_o),
    .red_in_i        (red_in_i),
    .green_in_i      (green_in_i),
    .blue_in_i       (blue_in_i),
    .done_o          (done_o),
    .hue_out_o       (hue_out_o),
    .hue_defined_o   (hue_defined_o),
    .saturation_out_o(saturation_out_o),
    .value_out_o     (value_out_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic hsv_t convert_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                                         logic [ChanW-1:0] b);
    int    rr, gg, bb, mx, mn, d, num, q, h;
    sext_e sext;
    hsv_t  res;
    rr = r;
    gg = g;
    bb = b;
    mx = (rr > gg) ? rr : gg;
    mx = (mx > bb) ? mx : bb;
    mn = (rr < gg) ? rr : gg;
    mn = (mn < bb) ? mn : bb;
    d = mx - mn;
    res = '0;
    res.val = mx[ChanW-1:0];
    if (mx > 0) res.sat = ChanW'((255 * d) / mx);
    if (d > 0) begin
      res.defined = 1'b1;
      // ties go to the first of red, green, blue
      if (rr == mx) sext = SEXT_RED;
      else if (gg == mx) sext = SEXT_GREEN;
      else sext = SEXT_BLUE;
      case (sext)
        SEXT_RED: begin
          num = SextantStep * (gg - bb);
          h = 0;
        end
        SEXT_GREEN: begin
          num = SextantStep * (bb - rr);
          h = 2 * SextantStep;
        end
        default: begin
          num = SextantStep * (rr - gg);
          h = 4 * SextantStep;
        end
      endcase
      // floor rather than truncate toward zero
      q = num / d;
      if (num < 0 && q * d != num) q = q - 1;
      h = h + q;
      if (h < 0) h = h + HueFull;
      res.hue = h[HueW-1:0];
    end
    return res;
  endfunction

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatches++;
  endtask

  // outputs sampled on the rising edge, before the design updates them
  always @(posedge clk_i) begin : result_check
    hsv_t want;
    if (rst_ni) begin
      if (done_o) begin
        if (pending_hsv.size() == 0) begin
          report_mismatch("done beat with no pixel outstanding");
        end else begin
          want = pending_hsv.pop_front();
          if (hue_out_o !== want.hue)
            report_mismatch($sformatf("hue %0d, want %0d", hue_out_o, want.hue));
          if (hue_defined_o !== want.defined)
            report_mismatch($sformatf("hue_defined %b, want %b", hue_defined_o,
                                      want.defined));
          if (saturation_out_o !== want.sat)
            report_mismatch($sformatf("saturation %0d, want %0d", saturation_out_o,
                                      want.sat));
          if (value_out_o !== want.val)
            report_mismatch($sformatf("value %0d, want %0d", value_out_o, want.val));
        end
      end
      if (start_i && !busy_o)
        pending_hsv.insert(pending_hsv.size(),
                           convert_pixel(red_in_i, green_in_i, blue_in_i));
    end
  end

  task automatic idle_cycles(int n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
      // junk on the data lines while start is low
      red_in_i <= ChanW'($urandom);
      green_in_i <= ChanW'($urandom);
      blue_in_i <= ChanW'($urandom);
    end
  endtask

  task automatic send_pixel(logic [ChanW-1:0] r, logic [ChanW-1:0] g,
                            logic [ChanW-1:0] b);
    if (burst_left == 0) begin
      if (!no_gaps) idle_cycles($urandom_range(0, 7));
      burst_left = $urandom_range(1, 24);
    end
    @(negedge clk_i);
    start_i <= 1'b1;
    red_in_i <= r;
    green_in_i <= g;
    blue_in_i <= b;
    do @(posedge clk_i); while (busy_o);
    burst_left--;
  endtask

  function automatic logic [ChanW-1:0] pick_channel(int mode);
    case (mode)
      0: return ChanW'($urandom_range(0, 3));
      1: begin
        case ($urandom_range(0, 3))
          0: return 8'd0;
          1: return 8'd1;
          2: return 8'd254;
          default: return 8'd255;
        endcase
      end
      default: return ChanW'($urandom);
    endcase
  endfunction

  task automatic send_random_pixel();
    int               mode, pick;
    logic [ChanW-1:0] r, g, b;
    pick = $urandom_range(0, 99);
    mode = (pick < 10) ? 0 : (pick < 20) ? 1 : 2;
    r = pick_channel(mode);
    g = pick_channel(mode);
    b = pick_channel(mode);
    // force ties and greys now and then
    case ($urandom_range(0, 9))
      0: g = r;
      1: b = g;
      2: b = r;
      3: begin
        g = r;
        b = r;
      end
      default: ;
    endcase
    send_pixel(r, g, b);
  endtask

  task automatic wait_drained();
    @(negedge clk_i);
    start_i <= 1'b0;
    while (pending_hsv.size() != 0) @(negedge clk_i);
  endtask

  task automatic test_corner_pixels();
    send_pixel(8'd0, 8'd0, 8'd0);       // black
    send_pixel(8'd255, 8'd255, 8'd255); // white
    send_pixel(8'd128, 8'd128, 8'd128); // grey
    send_pixel(8'd1, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);   // red and green tie
    send_pixel(8'd0, 8'd255, 8'd255);   // green and blue tie
    send_pixel(8'd255, 8'd0, 8'd255);   // red and blue tie
    send_pixel(8'd255, 8'd0, 8'd1);     // negative hue, wraps near the top
    send_pixel(8'd1, 8'd0, 8'd1);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd254, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd254, 8'd255);
    send_pixel(8'd170, 8'd85, 8'd0);
    send_pixel(8'd1, 8'd255, 8'd0);
    send_pixel(8'd255, 8'd1, 8'd0);
    send_pixel(8'd0, 8'd1, 8'd255);
  endtask

  task automatic test_random_pixels(int count);
    repeat (count) send_random_pixel();
  endtask

  task automatic test_back_to_back(int count);
    no_gaps = 1'b1;
    repeat (count) send_random_pixel();
    no_gaps = 1'b0;
  endtask

  task automatic test_after_drain(int count);
    wait_drained();
    repeat (count) send_random_pixel();
  endtask

  initial begin
    int n;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    idle_cycles(2);

    test_corner_pixels();
    test_random_pixels(400);
    test_back_to_back(150);
    test_after_drain(30);
    test_random_pixels(50);

    @(negedge clk_i);
    start_i <= 1'b0;
    for (n = 0; n < 500 && pending_hsv.size() != 0; n++) @(posedge clk_i);
    repeat (ResultLatency + 4) @(posedge clk_i);
    if (pending_hsv.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", pending_hsv.size()));
    if (mismatches == 0) begin
      $display("rgb_to_hsv_pixel verification clean");
    end else begin
      $display("rgb_to_hsv_pixel verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("rgb_to_hsv_pixel verification failed");
    $finish;
  end

endmodule
